/* hdl/sirs_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Radix symbol conversion package
// Shared widths, register indexes and the queue entry type.
// -----------------------------------------------------------------------------
package sirs_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int VALUE_W     = 32;
   localparam int MAG_W       = 32;
   localparam int DIGIT_W     = 5;
   localparam int SYM_W       = 8;
   localparam int LEN_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int SYM_REGS    = 4;
   localparam int SYMS_PER_REG = 8;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOLS_3 = 3'd4;

   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

   // Classified transaction handed from the front part to the back part.
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } job_type;

endpackage

/* hdl/sirs_front.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Radix symbol conversion front end
// Holds configuration, checks the base and classifies incoming values.
// -----------------------------------------------------------------------------
module sirs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sirs_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [sirs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_push,
   input  logic signed [sirs_pkg::VALUE_W-1:0] req_value,
   output logic                                req_full,
   input  logic                                q_full,
   output logic                                q_push,
   output sirs_pkg::job_type                   q_data,
   output logic [sirs_pkg::LEN_W-1:0]          base_len,
   output logic [sirs_pkg::MAX_SYMBOLS*sirs_pkg::SYM_W-1:0] symbols
);

   logic [sirs_pkg::LEN_W-1:0] base_len_ff;
   logic [sirs_pkg::SYM_REGS*sirs_pkg::CSR_DATA_W-1:0] sym_ff;
   logic                       check_busy_ff, check_busy_in;
   logic [sirs_pkg::DIGIT_W-1:0] chk_i_ff, chk_i_in;
   logic                       base_ok_ff, base_ok_in;
   logic                       bad_now;
   logic [sirs_pkg::SYM_W-1:0] ci;
   logic                       accept;

   // Register writes; any write restarts the base check.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_len_ff <= '0;
         sym_ff      <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            sirs_pkg::REG_BASE_LEN:  base_len_ff <= csr_wdata[sirs_pkg::LEN_W-1:0];
            sirs_pkg::REG_SYMBOLS_0: sym_ff[0*64 +: 64] <= csr_wdata;
            sirs_pkg::REG_SYMBOLS_1: sym_ff[1*64 +: 64] <= csr_wdata;
            sirs_pkg::REG_SYMBOLS_2: sym_ff[2*64 +: 64] <= csr_wdata;
            sirs_pkg::REG_SYMBOLS_3: sym_ff[3*64 +: 64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One symbol per cycle is checked for zero and sign bytes and compared against the symbols after it.
   always_comb begin
      ci = sym_ff[chk_i_ff*sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
      bad_now = 1'b0;
      if ({1'b0, chk_i_ff} < base_len_ff) begin
         if (ci == '0 || ci == sirs_pkg::CHAR_PLUS || ci == sirs_pkg::CHAR_MINUS)
            bad_now = 1'b1;
         for (int j = 0; j < sirs_pkg::MAX_SYMBOLS; j++) begin
            if (j > int'(chk_i_ff) && j < int'(base_len_ff) &&
                sym_ff[j*sirs_pkg::SYM_W +: sirs_pkg::SYM_W] == ci)
               bad_now = 1'b1;
         end
      end
   end

   always_comb begin
      check_busy_in = check_busy_ff;
      chk_i_in      = chk_i_ff;
      base_ok_in    = base_ok_ff;
      if (csr_we) begin
         check_busy_in = 1'b1;
         chk_i_in      = '0;
         base_ok_in    = 1'b1;
      end else if (check_busy_ff) begin
         if (bad_now) base_ok_in = 1'b0;
         chk_i_in = chk_i_ff + 1'b1;
         if (chk_i_ff == '1) check_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_busy_ff <= 1'b1;
         chk_i_ff      <= '0;
         base_ok_ff    <= 1'b1;
      end else begin
         check_busy_ff <= check_busy_in;
         chk_i_ff      <= chk_i_in;
         base_ok_ff    <= base_ok_in;
      end
   end

   // Classification: sign and 32-bit magnitude; an invalid base drops the value.
   assign req_full = q_full | check_busy_ff;
   assign accept   = req_push & ~req_full;
   assign q_push   = accept & base_ok_ff & (base_len_ff >= 6'd2)
                     & (base_len_ff <= 6'(sirs_pkg::MAX_SYMBOLS));
   assign q_data.neg = req_value[sirs_pkg::VALUE_W-1];
   assign q_data.mag = req_value[sirs_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
   assign base_len = base_len_ff;
   assign symbols  = sym_ff;

   a_no_push_busy: assert property (@(posedge clock) disable iff (reset)
      check_busy_ff |-> !q_push) else $error("push during base check");
   a_push_valid_len: assert property (@(posedge clock) disable iff (reset)
      q_push |-> base_len_ff >= 6'd2) else $error("push with short base");
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> check_busy_ff) else $error("check not restarted");

endmodule

/* hdl/sirs_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Radix symbol conversion job queue
// Two-entry queue between the front and back parts.
// -----------------------------------------------------------------------------
module sirs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sirs_pkg::job_type wdata,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output sirs_pkg::job_type rdata
);

   sirs_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= wdata;
   end

   // Pointer and occupancy tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      empty |-> wp_ff == rp_ff) else $error("pointer mismatch");
   a_full_ptr: assert property (@(posedge clock) disable iff (reset)
      full |-> wp_ff == rp_ff) else $error("pointer mismatch when full");

endmodule

/* hdl/sirs_back.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Radix symbol conversion back end
// Divides the magnitude bit-serially, stacks digits and emits symbols.
// -----------------------------------------------------------------------------
module sirs_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  sirs_pkg::job_type                  q_data,
   output logic                               q_pop,
   input  logic [sirs_pkg::LEN_W-1:0]         base_len,
   input  logic [sirs_pkg::MAX_SYMBOLS*sirs_pkg::SYM_W-1:0] symbols,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sirs_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                               rsp_last
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SIGN = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;

   logic [2:0]  st_ff, st_in;
   logic [sirs_pkg::MAG_W-1:0] quo_ff, quo_in;
   logic [sirs_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [4:0]  bit_ff, bit_in;
   logic [sirs_pkg::DIGIT_W-1:0] dig_ff [sirs_pkg::MAX_SYMBOLS];
   logic [5:0]  nd_ff, nd_in;
   logic        neg_ff, neg_in;
   logic        ov_ff, ov_in;
   logic [sirs_pkg::SYM_W-1:0] osym_ff, osym_in;
   logic        olast_ff, olast_in;
   logic        dwr;
   logic [sirs_pkg::LEN_W:0] trial;
   logic [sirs_pkg::LEN_W-1:0] rnew;
   logic [sirs_pkg::MAG_W-1:0] qn;
   logic [sirs_pkg::DIGIT_W-1:0] cur_dig;

   assign rsp_empty  = ~ov_ff;
   assign rsp_symbol = osym_ff;
   assign rsp_last   = olast_ff;

   // Restoring division step: one quotient bit per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[bit_ff]} - {1'b0, base_len};
      rnew  = trial[sirs_pkg::LEN_W] ? {rem_ff[sirs_pkg::LEN_W-2:0], quo_ff[bit_ff]}
                                     : trial[sirs_pkg::LEN_W-1:0];
      qn    = quo_ff;
      qn[bit_ff] = ~trial[sirs_pkg::LEN_W];
   end

   always_comb begin
      st_in = st_ff; quo_in = quo_ff; rem_in = rem_ff; bit_in = bit_ff;
      nd_in = nd_ff; neg_in = neg_ff; ov_in = ov_ff;
      osym_in = osym_ff; olast_in = olast_ff;
      q_pop = 1'b0; dwr = 1'b0;
      cur_dig = dig_ff[5'(nd_ff - 6'd1)];
      if (ov_ff && rsp_pop) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               quo_in = q_data.mag;
               neg_in = q_data.neg;
               rem_in = '0; bit_in = 5'd31; nd_in = '0;
               st_in  = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!neg_ff) st_in = ST_DIV;
            else if (!ov_ff || rsp_pop) begin
               ov_in = 1'b1; osym_in = sirs_pkg::CHAR_MINUS; olast_in = 1'b0;
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rnew;
            quo_in = qn;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == '0) begin
               dwr = 1'b1;
               nd_in = nd_ff + 6'd1;
               rem_in = '0; bit_in = 5'd31;
               if (qn == '0 || nd_ff == 6'd31) st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_pop) begin
               ov_in = 1'b1;
               osym_in = symbols[cur_dig*sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
               olast_in = (nd_ff == 6'd1);
               nd_in = nd_ff - 6'd1;
               if (nd_ff == 6'd1) st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Digit stack; the remainder is below the base so five bits suffice.
   always_ff @(posedge clock) begin
      if (dwr) dig_ff[nd_ff[4:0]] <= rnew[sirs_pkg::DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; nd_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; nd_ff <= nd_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; bit_ff <= bit_in;
      neg_ff <= neg_in; osym_ff <= osym_in; olast_ff <= olast_in;
   end

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EMIT |-> nd_ff != '0) else $error("empty digit stack");
   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp_pop |=> ov_ff && $stable(osym_ff)) else $error("output lost");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == ST_IDLE) else $error("pop while busy");

endmodule

/* hdl/signed_int_to_radix_symbols.sv */
`timescale 1ns / 1ps
// Throughput: one value at a time in the divider; a two-entry queue buffers the input.
// Each digit takes a full pass of the bit-serial restoring divider; digits are emitted most significant first.
// After reset or any register write, the base check holds req_full high.
// Reset is synchronous and active high; configuration registers reset to zero.
// -----------------------------------------------------------------------------
// Signed integer to radix symbols
// Top level joining front end, job queue and back end.
// -----------------------------------------------------------------------------
module signed_int_to_radix_symbols (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sirs_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [sirs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                push,
   input  logic signed [sirs_pkg::VALUE_W-1:0] req_value,
   output logic                                full,
   output logic                                empty,
   input  logic                                pop,
   output logic [sirs_pkg::SYM_W-1:0]          rsp_symbol,
   output logic                                rsp_last
);

   logic q_push, q_full, q_pop, q_empty;
   sirs_pkg::job_type q_wdata, q_rdata;
   logic [sirs_pkg::LEN_W-1:0] base_len;
   logic [sirs_pkg::MAX_SYMBOLS*sirs_pkg::SYM_W-1:0] symbols;

   sirs_front u_front (
      .clock, .reset, .csr_we, .csr_idx, .csr_wdata,
      .req_push(push), .req_value, .req_full(full),
      .q_full, .q_push, .q_data(q_wdata), .base_len, .symbols
   );

   sirs_queue u_queue (
      .clock, .reset, .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
   );

   sirs_back u_back (
      .clock, .reset, .q_empty, .q_data(q_rdata), .q_pop, .base_len, .symbols,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_symbol, .rsp_last
   );

endmodule

/* verif/tb_signed_int_to_radix_symbols.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Testbench for the signed integer to radix symbols converter
// Programs a series of radix tables, valid and invalid, sends signed values
// through the input queue and checks every emitted character and its end
// marker against a behavioural prediction of the conversion.
// -----------------------------------------------------------------------------
module tb_signed_int_to_radix_symbols;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1200;

   typedef struct {
      logic [sirs_pkg::SYM_W-1:0] symbol;
      logic                       last;
   } char_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [sirs_pkg::CSR_IDX_W-1:0]      csr_idx = sirs_pkg::REG_BASE_LEN;
   logic [sirs_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                                push = 1'b0;
   logic signed [sirs_pkg::VALUE_W-1:0] req_value = '0;
   logic                                full;
   logic                                empty;
   logic                                pop = 1'b0;
   logic [sirs_pkg::SYM_W-1:0]          rsp_symbol;
   logic                                rsp_last;

   // Values waiting to be sent and characters waiting to arrive.
   logic signed [sirs_pkg::VALUE_W-1:0] pending_values[$];
   char_type                            expected_chars[$];

   // Shadow copy of the configuration registers.
   logic [sirs_pkg::LEN_W-1:0]          radix;
   logic [sirs_pkg::CSR_DATA_W-1:0]     sym_table[sirs_pkg::SYM_REGS];

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;

   signed_int_to_radix_symbols u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_idx(csr_idx),
      .csr_wdata(csr_wdata), .push(push), .req_value(req_value), .full(full),
      .empty(empty), .pop(pop), .rsp_symbol(rsp_symbol), .rsp_last(rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Symbol byte for one digit value from the shadow table.
   function automatic logic [sirs_pkg::SYM_W-1:0] symbol_of(int unsigned d);
      return sym_table[d / sirs_pkg::SYMS_PER_REG]
                      [(d % sirs_pkg::SYMS_PER_REG) * sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
   endfunction

   // The table is usable only with a legal radix and distinct, printable-safe symbols.
   function automatic bit table_usable();
      logic [sirs_pkg::SYM_W-1:0] c;
      if (radix < 2 || radix > sirs_pkg::MAX_SYMBOLS) return 1'b0;
      for (int i = 0; i < radix; i++) begin
         c = symbol_of(i);
         if (c == 8'h00 || c == sirs_pkg::CHAR_PLUS || c == sirs_pkg::CHAR_MINUS)
            return 1'b0;
         for (int j = i + 1; j < radix; j++)
            if (symbol_of(j) == c) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Appends the characters that one value is written as.
   task automatic predict_text(logic signed [sirs_pkg::VALUE_W-1:0] v);
      logic [sirs_pkg::MAG_W:0] mag;
      int unsigned    digits[33];
      int             nd;
      char_type       ch;
      nd = 0;
      if (!table_usable()) return;
      if (v[sirs_pkg::VALUE_W-1]) begin
         mag = {1'b0, ~v} + 1'b1;
         ch.symbol = sirs_pkg::CHAR_MINUS;
         ch.last = 1'b0;
         expected_chars.push_back(ch);
      end else begin
         mag = {1'b0, v};
      end
      do begin
         digits[nd] = 32'(mag % radix);
         mag = mag / radix;
         nd++;
      end while (mag != 0 && nd < sirs_pkg::MAX_SYMBOLS);
      for (int i = nd - 1; i >= 0; i--) begin
         ch.symbol = symbol_of(digits[i]);
         ch.last = (i == 0);
         expected_chars.push_back(ch);
      end
   endtask

   // Input driver: holds an offered value until it is taken, idles at random.
   always @(posedge clock) begin : driver
      logic taken;
      taken = push && !full;
      if (taken) begin
         predict_text(req_value);
         void'(pending_values.pop_front());
      end
      if (reset) begin
         push <= 1'b0;
      end else if (push && !taken) begin
         push <= 1'b1;
      end else if (pending_values.size() > 0 &&
                   (no_idle || $urandom_range(0, 99) >= 10)) begin
         push <= 1'b1;
         req_value <= pending_values[0];
      end else begin
         push <= 1'b0;
      end
   end

   // Output monitor: checks each character transaction, stalls at random.
   always @(posedge clock) begin : monitor
      char_type exp_ch;
      if (pop && !empty) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character %02h last %0b", rsp_symbol, rsp_last);
            errors++;
         end else begin
            exp_ch = expected_chars.pop_front();
            if (rsp_symbol !== exp_ch.symbol) begin
               $error("symbol: expected %02h, got %02h", exp_ch.symbol, rsp_symbol);
               errors++;
            end
            if (rsp_last !== exp_ch.last) begin
               $error("last: expected %0b, got %0b", exp_ch.last, rsp_last);
               errors++;
            end
         end
      end
      pop <= !reset && (no_idle || $urandom_range(0, 99) >= 10);
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [sirs_pkg::CSR_IDX_W-1:0] idx,
                            logic [sirs_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      if (idx == sirs_pkg::REG_BASE_LEN)
         radix = data[sirs_pkg::LEN_W-1:0];
      else if (idx >= sirs_pkg::REG_SYMBOLS_0 && idx <= sirs_pkg::REG_SYMBOLS_3)
         sym_table[idx - sirs_pkg::REG_SYMBOLS_0] = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Loads a full table of 32 bytes, with the upper bits of the length word random.
   task automatic load_table(logic [sirs_pkg::LEN_W-1:0] len,
                             logic [sirs_pkg::SYM_W-1:0] bytes[sirs_pkg::MAX_SYMBOLS]);
      logic [sirs_pkg::CSR_DATA_W-1:0] w;
      for (int r = 0; r < sirs_pkg::SYM_REGS; r++) begin
         for (int b = 0; b < sirs_pkg::SYMS_PER_REG; b++)
            w[b * sirs_pkg::SYM_W +: sirs_pkg::SYM_W] = bytes[r * sirs_pkg::SYMS_PER_REG + b];
         write_reg(3'(sirs_pkg::REG_SYMBOLS_0 + r), w);
      end
      write_reg(sirs_pkg::REG_BASE_LEN, {$urandom, $urandom} & ~64'(6'h3F) | 64'(len));
   endtask

   // Random distinct symbols for the used slots, anything at all elsewhere.
   task automatic random_table(int len,
                               output logic [sirs_pkg::SYM_W-1:0] bytes[sirs_pkg::MAX_SYMBOLS]);
      bit clash;
      for (int i = 0; i < sirs_pkg::MAX_SYMBOLS; i++) begin
         bytes[i] = 8'($urandom_range(0, 255));
         if (i < len) begin
            do begin
               bytes[i] = 8'($urandom_range(0, 255));
               clash = bytes[i] == 8'h00 || bytes[i] == sirs_pkg::CHAR_PLUS ||
                       bytes[i] == sirs_pkg::CHAR_MINUS;
               for (int j = 0; j < i; j++)
                  if (bytes[j] == bytes[i]) clash = 1'b1;
            end while (clash);
         end
      end
   endtask

   function automatic logic signed [sirs_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? -$urandom_range(0, 1000) : $urandom_range(0, 1000);
         2: return $urandom_range(0, 1) ? 32'sh8000_0000 + $urandom_range(0, 3)
                                          : 32'sh7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // Sends the directed values then n random ones, and waits for the block to drain.
   task automatic run_values(int n);
      logic signed [sirs_pkg::VALUE_W-1:0] v;
      v = radix;
      pending_values = {pending_values, 0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        32'sh8000_0001, v - 1, v, -v, v * v - 1, -(v * v)};
      repeat (n) pending_values.push_back(random_value());
      while (pending_values.size() > 0 || push || expected_chars.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [sirs_pkg::SYM_W-1:0] bytes[sirs_pkg::MAX_SYMBOLS];
      int n_sym;
      radix = '0;
      for (int r = 0; r < sirs_pkg::SYM_REGS; r++) sym_table[r] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset state: a zero radix gives no output at all.
      run_values(0);

      // Decimal, binary and hexadecimal with the usual digits.
      for (int i = 0; i < sirs_pkg::MAX_SYMBOLS; i++)
         bytes[i] = i < 10 ? 8'(8'h30 + i) : 8'(8'h61 + i - 10);
      load_table(6'd10, bytes);
      run_values(40);
      write_reg(sirs_pkg::REG_BASE_LEN, 64'd2);
      run_values(40);

      // Hexadecimal without any idling on either side.
      no_idle = 1'b1;
      write_reg(sirs_pkg::REG_BASE_LEN, 64'd16);
      run_values(40);
      no_idle = 1'b0;

      // Largest radix with random symbols.
      random_table(sirs_pkg::MAX_SYMBOLS, bytes);
      load_table(6'd32, bytes);
      run_values(40);

      // Invalid tables: too few or too many symbols, sign bytes, a repeat, a zero byte.
      write_reg(sirs_pkg::REG_BASE_LEN, 64'd1);
      run_values(2);
      write_reg(sirs_pkg::REG_BASE_LEN, 64'd33);
      run_values(2);
      write_reg(sirs_pkg::REG_BASE_LEN, 64'd63);
      run_values(2);
      random_table(12, bytes);
      bytes[$urandom_range(0, 11)] = sirs_pkg::CHAR_PLUS;
      load_table(6'd12, bytes);
      run_values(2);
      random_table(12, bytes);
      bytes[$urandom_range(0, 11)] = sirs_pkg::CHAR_MINUS;
      load_table(6'd12, bytes);
      run_values(2);
      random_table(12, bytes);
      bytes[11] = bytes[$urandom_range(0, 10)];
      load_table(6'd12, bytes);
      run_values(2);
      random_table(12, bytes);
      bytes[$urandom_range(0, 11)] = 8'h00;
      load_table(6'd12, bytes);
      run_values(2);

      // Unused register indexes must leave the table alone.
      random_table(7, bytes);
      load_table(6'd7, bytes);
      write_reg(3'(sirs_pkg::REG_SYMBOLS_3 + $urandom_range(1, 3)), {$urandom, $urandom});
      run_values(25);

      // Random radices with random tables.
      repeat (6) begin
         n_sym = $urandom_range(2, sirs_pkg::MAX_SYMBOLS);
         random_table(n_sym, bytes);
         load_table(6'(n_sym), bytes);
         run_values(25);
      end

      if (errors == 0 && expected_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
